// ----- rtl/rfc_pkg.sv -----
// ----------------------------------------------------------------------------
// rfc_pkg
// Types, constants and helpers shared by the receive frame classifier.
// ----------------------------------------------------------------------------
package rfc_pkg;

  typedef enum logic [3:0] {
    CLS_RUNT        = 4'd0,
    CLS_OTHER       = 4'd1,
    CLS_ARP_SHORT   = 4'd2,
    CLS_ARP_REQUEST = 4'd3,
    CLS_ARP_OTHER   = 4'd4,
    CLS_IPV4_BAD    = 4'd5,
    CLS_NOT_ICMP    = 4'd6,
    CLS_ICMP_OTHER  = 4'd7,
    CLS_ECHO_REPLY  = 4'd8
  } frame_class_t;

  localparam logic [15:0] TYPE_ARP       = 16'h0806;
  localparam logic [15:0] TYPE_IPV4      = 16'h0800;
  localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
  localparam logic [7:0]  PROTO_ICMP     = 8'h01;
  localparam logic [3:0]  IPV4_VERSION   = 4'd4;
  localparam logic [7:0]  IHL_MASK       = 8'h0F;
  localparam int          IHL_UNIT       = 4;

  localparam int ETH_HDR_LEN   = 14;
  localparam int ARP_FRAME_LEN = 42;
  localparam int IPV4_MIN_HDR  = 20;
  localparam int ICMP_HDR_LEN  = 8;

  localparam int OFS_TYPE_HI    = 12;
  localparam int OFS_TYPE_LO    = 13;
  localparam int OFS_ARP_OP_HI  = 20;
  localparam int OFS_ARP_OP_LO  = 21;
  localparam int OFS_ARP_MAC_LO = 22;
  localparam int OFS_ARP_MAC_HI = 27;
  localparam int OFS_ARP_IP_LO  = 28;
  localparam int OFS_ARP_IP_HI  = 31;
  localparam int OFS_IP_VER_IHL = 14;
  localparam int OFS_IP_TOT_HI  = 16;
  localparam int OFS_IP_TOT_LO  = 17;
  localparam int OFS_IP_PROTO   = 23;
  localparam int OFS_IP_SRC_LO  = 26;
  localparam int OFS_IP_SRC_HI  = 29;
  localparam int OFS_ICMP_CSUM0 = 2;
  localparam int OFS_ICMP_CSUM1 = 3;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [15:0] arp_opcode;
    logic [47:0] src_mac;
    logic [31:0] addr;
    logic [7:0]  ver_ihl;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [47:0] icmp_hdr;
  } frame_fields_t;

  typedef struct packed {
    frame_class_t frame_class;
    logic [15:0]  ether_type;
    logic [31:0]  peer_ip;
    logic [47:0]  peer_mac;
    logic [15:0]  echo_id;
    logic [15:0]  echo_seq;
    logic [11:0]  echo_payload_len;
    logic         arp_learn;
  } verdict_t;

  function automatic logic [5:0] ihl_bytes(input logic [7:0] ver_ihl);
    logic [7:0] m;
    m = ver_ihl & IHL_MASK;
    return 6'(m[3:0] * IHL_UNIT);
  endfunction

endpackage

// ----- rtl/rfc_capture.sv -----
// ----------------------------------------------------------------------------
// rfc_capture
// Byte counter and per-frame header registers, with the next-state values
// that include the byte currently being consumed.
// ----------------------------------------------------------------------------
module rfc_capture #(
  parameter int MAX_FRAME = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output rfc_pkg::frame_fields_t fields_next,
  output logic [$clog2(MAX_FRAME+1)-1:0] len_next
);
  import rfc_pkg::*;

  localparam int CW = $clog2(MAX_FRAME + 1);

  frame_fields_t fields;
  logic [CW-1:0] count;
  logic          take;
  logic [5:0]    ihl;
  logic [CW:0]   icmp_base;
  logic [CW:0]   ofs;

  always_comb begin
    fields_next = fields;
    len_next    = count;
    take        = count < CW'(MAX_FRAME);
    ihl         = '0;
    icmp_base   = '0;
    ofs         = '0;
    if (take) begin
      len_next = count + 1'b1;
      if (count == CW'(OFS_TYPE_HI)) begin
        fields_next.ether_type = {data_byte, 8'h00};
      end else if (count == CW'(OFS_TYPE_LO)) begin
        fields_next.ether_type[7:0] = data_byte;
      end else if (count >= CW'(ETH_HDR_LEN)) begin
        if (fields.ether_type == TYPE_ARP) begin
          if (count == CW'(OFS_ARP_OP_HI) || count == CW'(OFS_ARP_OP_LO)) begin
            fields_next.arp_opcode = {fields.arp_opcode[7:0], data_byte};
          end else if (count >= CW'(OFS_ARP_MAC_LO) && count <= CW'(OFS_ARP_MAC_HI)) begin
            fields_next.src_mac = {fields.src_mac[39:0], data_byte};
          end else if (count >= CW'(OFS_ARP_IP_LO) && count <= CW'(OFS_ARP_IP_HI)) begin
            fields_next.addr = {fields.addr[23:0], data_byte};
          end
        end else if (fields.ether_type == TYPE_IPV4) begin
          if (count == CW'(OFS_IP_VER_IHL)) begin
            fields_next.ver_ihl = data_byte;
          end else if (count == CW'(OFS_IP_TOT_HI) || count == CW'(OFS_IP_TOT_LO)) begin
            fields_next.total_len = {fields.total_len[7:0], data_byte};
          end else if (count == CW'(OFS_IP_PROTO)) begin
            fields_next.proto = data_byte;
          end else if (count >= CW'(OFS_IP_SRC_LO) && count <= CW'(OFS_IP_SRC_HI)) begin
            fields_next.addr = {fields.addr[23:0], data_byte};
          end
          ihl       = ihl_bytes(fields_next.ver_ihl);
          icmp_base = (CW+1)'(ETH_HDR_LEN) + (CW+1)'(ihl);
          if ({1'b0, count} >= icmp_base) begin
            ofs = {1'b0, count} - icmp_base;
            if (ofs < (CW+1)'(ICMP_HDR_LEN) && ofs != (CW+1)'(OFS_ICMP_CSUM0) &&
                ofs != (CW+1)'(OFS_ICMP_CSUM1)) begin
              fields_next.icmp_hdr = {fields.icmp_hdr[39:0], data_byte};
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      fields <= '0;
    end else if (step) begin
      if (last_byte) begin
        count  <= '0;
        fields <= '0;
      end else begin
        count  <= len_next;
        fields <= fields_next;
      end
    end
  end

endmodule

// ----- rtl/rfc_classify.sv -----
// ----------------------------------------------------------------------------
// rfc_classify
// Verdict logic: frame class, peer address, echo fields and the ARP learn
// flag, from the header fields and length of a completed frame.
// ----------------------------------------------------------------------------
module rfc_classify #(
  parameter int MAX_FRAME = 2048
) (
  input  rfc_pkg::frame_fields_t fields,
  input  logic [$clog2(MAX_FRAME+1)-1:0] len,
  output rfc_pkg::verdict_t      verdict
);
  import rfc_pkg::*;

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int LW = ((CW > 16) ? CW : 16) + 1;

  logic [LW-1:0] len_w;
  logic [LW-1:0] iplen;
  logic [LW-1:0] ihl_w;
  logic [LW-1:0] tot_w;
  logic [LW-1:0] ilen;
  logic          bad;

  always_comb begin
    len_w   = LW'(len);
    iplen   = len_w - LW'(ETH_HDR_LEN);
    ihl_w   = LW'(ihl_bytes(fields.ver_ihl));
    tot_w   = LW'(fields.total_len);
    ilen    = tot_w - ihl_w;
    bad     = iplen < LW'(IPV4_MIN_HDR) || fields.ver_ihl[7:4] != IPV4_VERSION ||
              ihl_w < LW'(IPV4_MIN_HDR) || iplen < ihl_w || tot_w < ihl_w ||
              tot_w > iplen;
    verdict = '0;
    verdict.frame_class = CLS_RUNT;
    if (len_w >= LW'(ETH_HDR_LEN)) begin
      verdict.ether_type = fields.ether_type;
      if (fields.ether_type == TYPE_ARP) begin
        if (len_w < LW'(ARP_FRAME_LEN)) begin
          verdict.frame_class = CLS_ARP_SHORT;
        end else begin
          verdict.arp_learn   = 1'b1;
          verdict.frame_class = (fields.arp_opcode == ARP_OP_REQUEST) ?
                                CLS_ARP_REQUEST : CLS_ARP_OTHER;
          verdict.peer_ip     = fields.addr;
          verdict.peer_mac    = fields.src_mac;
        end
      end else if (fields.ether_type == TYPE_IPV4) begin
        if (bad) begin
          verdict.frame_class = CLS_IPV4_BAD;
        end else if (fields.proto != PROTO_ICMP) begin
          verdict.frame_class = CLS_NOT_ICMP;
          verdict.peer_ip     = fields.addr;
        end else begin
          verdict.peer_ip = fields.addr;
          if (ilen >= LW'(ICMP_HDR_LEN) && fields.icmp_hdr[47:40] == 8'h00 &&
              fields.icmp_hdr[39:32] == 8'h00) begin
            verdict.frame_class      = CLS_ECHO_REPLY;
            verdict.echo_id          = fields.icmp_hdr[31:16];
            verdict.echo_seq         = fields.icmp_hdr[15:0];
            verdict.echo_payload_len = 12'(ilen - LW'(ICMP_HDR_LEN));
          end else begin
            verdict.frame_class = CLS_ICMP_OTHER;
          end
        end
      end else begin
        verdict.frame_class = CLS_OTHER;
      end
    end
  end

endmodule

// ----- rtl/rx_frame_classifier_arp_cache_unit.sv -----
// ----------------------------------------------------------------------------
// rx_frame_classifier_arp_cache_unit
// A verdict is loaded into the output register as its last byte leaves the input register.
// Throughput: one byte per cycle; the header capture is a single register
// pass. A last byte waits in the input register only while the previous
// verdict is still held in the output register.
// Reset: synchronous; clears the frame registers and the ARP cache entry.
// ----------------------------------------------------------------------------
module rx_frame_classifier_arp_cache_unit #(
  parameter int MAX_FRAME = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_valid,
  output logic        frame_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        verdict_valid,
  input  logic        verdict_ready,
  output logic [3:0]  frame_class,
  output logic [15:0] ether_type,
  output logic [31:0] peer_ip,
  output logic [47:0] peer_mac,
  output logic [15:0] echo_id,
  output logic [15:0] echo_seq,
  output logic [11:0] echo_payload_len,
  output logic        cache_valid,
  output logic [31:0] cache_ip,
  output logic [47:0] cache_mac
);
  import rfc_pkg::*;

  localparam int CW = $clog2(MAX_FRAME + 1);

  logic          in_full;
  logic [7:0]    byte_q;
  logic          last_q;
  logic          advance;
  logic          finish;
  frame_fields_t fields_next;
  logic [CW-1:0] len_next;
  verdict_t      verdict;
  logic          entry_valid;
  logic [31:0]   entry_ip;
  logic [47:0]   entry_mac;
  logic          entry_valid_next;
  logic [31:0]   entry_ip_next;
  logic [47:0]   entry_mac_next;
  frame_class_t  class_q;

  assign advance     = in_full && (!last_q || !verdict_valid || verdict_ready);
  assign finish      = advance && last_q;
  assign frame_ready = !in_full || advance;
  assign frame_class = class_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (frame_ready) begin
      in_full <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      byte_q <= data_byte;
      last_q <= last_byte;
    end
  end

  rfc_capture #(
    .MAX_FRAME(MAX_FRAME)
  ) u_capture (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data_byte  (byte_q),
    .last_byte  (last_q),
    .fields_next(fields_next),
    .len_next   (len_next)
  );

  rfc_classify #(
    .MAX_FRAME(MAX_FRAME)
  ) u_classify (
    .fields (fields_next),
    .len    (len_next),
    .verdict(verdict)
  );

  always_comb begin
    entry_valid_next = entry_valid;
    entry_ip_next    = entry_ip;
    entry_mac_next   = entry_mac;
    if (verdict.arp_learn) begin
      entry_valid_next = 1'b1;
      entry_ip_next    = verdict.peer_ip;
      entry_mac_next   = verdict.peer_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      entry_ip    <= '0;
      entry_mac   <= '0;
    end else if (finish) begin
      entry_valid <= entry_valid_next;
      entry_ip    <= entry_ip_next;
      entry_mac   <= entry_mac_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
      cache_valid   <= 1'b0;
    end else begin
      if (finish) begin
        verdict_valid <= 1'b1;
        cache_valid   <= entry_valid_next;
      end else if (verdict_ready) begin
        verdict_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      class_q          <= verdict.frame_class;
      ether_type       <= verdict.ether_type;
      peer_ip          <= verdict.peer_ip;
      peer_mac         <= verdict.peer_mac;
      echo_id          <= verdict.echo_id;
      echo_seq         <= verdict.echo_seq;
      echo_payload_len <= verdict.echo_payload_len;
      cache_ip         <= entry_ip_next;
      cache_mac        <= entry_mac_next;
    end
  end

endmodule

// ----- rtl/rfc_checker.sv -----
// ----------------------------------------------------------------------------
// rfc_checker
// Port-level checks on the verdict word and the reported ARP cache entry.
// ----------------------------------------------------------------------------
module rfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        verdict_valid,
  input logic        verdict_ready,
  input logic [3:0]  frame_class,
  input logic [15:0] ether_type,
  input logic [31:0] peer_ip,
  input logic [47:0] peer_mac,
  input logic [15:0] echo_id,
  input logic [15:0] echo_seq,
  input logic        cache_valid,
  input logic [31:0] cache_ip,
  input logic [47:0] cache_mac
);
  import rfc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && !verdict_ready |=>
      verdict_valid && $stable(frame_class) && $stable(peer_ip) && $stable(cache_mac))
    else $error("Stalled verdict word changed.");

  a_cache_keep: assert property (@(posedge clk) disable iff (rst)
    cache_valid |=> cache_valid)
    else $error("Cache entry lost its mapping.");

  a_arp_learn: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && (frame_class == 4'(CLS_ARP_REQUEST) ||
                      frame_class == 4'(CLS_ARP_OTHER)) |->
      cache_valid && cache_ip == peer_ip && cache_mac == peer_mac)
    else $error("ARP verdict does not match the cache entry.");

  a_runt: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && frame_class == 4'(CLS_RUNT) |->
      ether_type == 16'h0000 && peer_ip == 32'h0 && peer_mac == 48'h0)
    else $error("Runt verdict carries header fields.");

  a_echo: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && frame_class != 4'(CLS_ECHO_REPLY) |->
      echo_id == 16'h0000 && echo_seq == 16'h0000)
    else $error("Echo fields set on a non-reply verdict.");

endmodule

bind rx_frame_classifier_arp_cache_unit rfc_checker u_rfc_checker (.*);

// ----- tb/sv/frame_verdict_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_verdict_checker
// Watches the byte and verdict channels of the receive frame classifier.
// Every accepted word feeds a local model of the header capture and of the
// one-entry ARP cache. Each last word queues the expected verdict. Each
// accepted verdict is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module frame_verdict_checker #(
  parameter int MAX_FRAME = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_valid,
  input  logic        frame_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        verdict_valid,
  input  logic        verdict_ready,
  input  logic [3:0]  frame_class,
  input  logic [15:0] ether_type,
  input  logic [31:0] peer_ip,
  input  logic [47:0] peer_mac,
  input  logic [15:0] echo_id,
  input  logic [15:0] echo_seq,
  input  logic [11:0] echo_payload_len,
  input  logic        cache_valid,
  input  logic [31:0] cache_ip,
  input  logic [47:0] cache_mac,
  output int          mismatch_count,
  output int          verdicts_pending,
  output int          verdicts_checked
);
  import rfc_pkg::*;

  typedef struct packed {
    frame_class_t cls;
    logic [15:0]  etype;
    logic [31:0]  ip;
    logic [47:0]  mac;
    logic [15:0]  id;
    logic [15:0]  seq;
    logic [11:0]  plen;
    logic         cvalid;
    logic [31:0]  cip;
    logic [47:0]  cmac;
  } verdict_rec_t;

  verdict_rec_t pending_verdicts[$];

  int          byte_pos;
  logic [15:0] etype_acc;
  logic [15:0] arp_op_acc;
  logic [47:0] arp_mac_acc;
  logic [31:0] peer_ip_acc;
  logic [7:0]  ver_ihl_acc;
  logic [15:0] tot_len_acc;
  logic [7:0]  proto_acc;
  logic [47:0] icmp_acc;
  logic        entry_ok;
  logic [31:0] entry_ip_q;
  logic [47:0] entry_mac_q;
  int          errors;
  int          checked;

  function automatic string verdict_text(input verdict_rec_t v);
    return $sformatf("class=%0d(%s) type=%h ip=%h mac=%h id=%h seq=%h len=%0d cache=%b/%h/%h",
                     v.cls, v.cls.name(), v.etype, v.ip, v.mac, v.id, v.seq, v.plen,
                     v.cvalid, v.cip, v.cmac);
  endfunction

  always @(posedge clk) begin
    verdict_rec_t got_v;
    verdict_rec_t want_v;
    int ihl_b;
    int ofs;
    int ip_len;
    int tot;
    if (rst) begin
      byte_pos = 0;
      etype_acc = '0;
      arp_op_acc = '0;
      arp_mac_acc = '0;
      peer_ip_acc = '0;
      ver_ihl_acc = '0;
      tot_len_acc = '0;
      proto_acc = '0;
      icmp_acc = '0;
      entry_ok = 1'b0;
      entry_ip_q = '0;
      entry_mac_q = '0;
      errors = 0;
      checked = 0;
      pending_verdicts.delete();
    end else begin
      if (verdict_valid && verdict_ready) begin
        got_v.cls = frame_class_t'(frame_class);
        got_v.etype = ether_type;
        got_v.ip = peer_ip;
        got_v.mac = peer_mac;
        got_v.id = echo_id;
        got_v.seq = echo_seq;
        got_v.plen = echo_payload_len;
        got_v.cvalid = cache_valid;
        got_v.cip = cache_ip;
        got_v.cmac = cache_mac;
        if (pending_verdicts.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("[%0t] unexpected verdict: %s", $realtime, verdict_text(got_v));
          end
        end else begin
          want_v = pending_verdicts.pop_front();
          checked++;
          if (got_v !== want_v) begin
            errors++;
            if (errors <= 10) begin
              $display("[%0t] verdict %0d mismatch", $realtime, checked);
              $display("  expected %s", verdict_text(want_v));
              $display("  actual   %s", verdict_text(got_v));
            end
          end
        end
      end

      if (frame_valid && frame_ready) begin
        if (byte_pos < MAX_FRAME) begin
          if (byte_pos == OFS_TYPE_HI) begin
            etype_acc = {data_byte, 8'h00};
          end else if (byte_pos == OFS_TYPE_LO) begin
            etype_acc[7:0] = data_byte;
          end else if (byte_pos >= ETH_HDR_LEN) begin
            if (etype_acc == TYPE_ARP) begin
              if (byte_pos == OFS_ARP_OP_HI || byte_pos == OFS_ARP_OP_LO) begin
                arp_op_acc = {arp_op_acc[7:0], data_byte};
              end else if (byte_pos >= OFS_ARP_MAC_LO && byte_pos <= OFS_ARP_MAC_HI) begin
                arp_mac_acc = {arp_mac_acc[39:0], data_byte};
              end else if (byte_pos >= OFS_ARP_IP_LO && byte_pos <= OFS_ARP_IP_HI) begin
                peer_ip_acc = {peer_ip_acc[23:0], data_byte};
              end
            end else if (etype_acc == TYPE_IPV4) begin
              if (byte_pos == OFS_IP_VER_IHL) begin
                ver_ihl_acc = data_byte;
              end else if (byte_pos == OFS_IP_TOT_HI || byte_pos == OFS_IP_TOT_LO) begin
                tot_len_acc = {tot_len_acc[7:0], data_byte};
              end else if (byte_pos == OFS_IP_PROTO) begin
                proto_acc = data_byte;
              end else if (byte_pos >= OFS_IP_SRC_LO && byte_pos <= OFS_IP_SRC_HI) begin
                peer_ip_acc = {peer_ip_acc[23:0], data_byte};
              end
              // The ICMP header moves with IHL, which may just have been taken.
              ihl_b = int'(ver_ihl_acc & IHL_MASK) * IHL_UNIT;
              if (byte_pos >= ETH_HDR_LEN + ihl_b) begin
                ofs = byte_pos - ETH_HDR_LEN - ihl_b;
                if (ofs < ICMP_HDR_LEN && ofs != OFS_ICMP_CSUM0 && ofs != OFS_ICMP_CSUM1) begin
                  icmp_acc = {icmp_acc[39:0], data_byte};
                end
              end
            end
          end
          byte_pos++;
        end

        if (last_byte) begin
          want_v = '0;
          want_v.cls = CLS_RUNT;
          if (byte_pos >= ETH_HDR_LEN) begin
            want_v.etype = etype_acc;
            if (etype_acc == TYPE_ARP) begin
              if (byte_pos < ARP_FRAME_LEN) begin
                want_v.cls = CLS_ARP_SHORT;
              end else begin
                entry_ok = 1'b1;
                entry_ip_q = peer_ip_acc;
                entry_mac_q = arp_mac_acc;
                want_v.cls = (arp_op_acc == ARP_OP_REQUEST) ? CLS_ARP_REQUEST : CLS_ARP_OTHER;
                want_v.ip = peer_ip_acc;
                want_v.mac = arp_mac_acc;
              end
            end else if (etype_acc == TYPE_IPV4) begin
              ip_len = byte_pos - ETH_HDR_LEN;
              ihl_b = int'(ver_ihl_acc & IHL_MASK) * IHL_UNIT;
              tot = int'(tot_len_acc);
              if (ip_len < IPV4_MIN_HDR || ver_ihl_acc[7:4] != IPV4_VERSION ||
                  ihl_b < IPV4_MIN_HDR || ip_len < ihl_b || tot < ihl_b || tot > ip_len) begin
                want_v.cls = CLS_IPV4_BAD;
              end else if (proto_acc != PROTO_ICMP) begin
                want_v.cls = CLS_NOT_ICMP;
                want_v.ip = peer_ip_acc;
              end else begin
                want_v.ip = peer_ip_acc;
                if (tot - ihl_b >= ICMP_HDR_LEN && icmp_acc[47:32] == 16'h0000) begin
                  want_v.cls = CLS_ECHO_REPLY;
                  want_v.id = icmp_acc[31:16];
                  want_v.seq = icmp_acc[15:0];
                  want_v.plen = 12'(tot - ihl_b - ICMP_HDR_LEN);
                end else begin
                  want_v.cls = CLS_ICMP_OTHER;
                end
              end
            end else begin
              want_v.cls = CLS_OTHER;
            end
          end
          want_v.cvalid = entry_ok;
          want_v.cip = entry_ip_q;
          want_v.cmac = entry_mac_q;
          pending_verdicts.push_back(want_v);

          byte_pos = 0;
          etype_acc = '0;
          arp_op_acc = '0;
          arp_mac_acc = '0;
          peer_ip_acc = '0;
          ver_ihl_acc = '0;
          tot_len_acc = '0;
          proto_acc = '0;
          icmp_acc = '0;
        end
      end
    end
    mismatch_count <= errors;
    verdicts_pending <= pending_verdicts.size();
    verdicts_checked <= checked;
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Frame-level stimulus for the receive frame classifier with ARP cache.
// A directed set of frames covers runts, other ethertypes, short and full
// ARP frames, every malformed IPv4 case and ICMP variants.
// Random frames follow, mostly well-formed ARP and echo replies with random
// content, mixed with broken headers and noise, under random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
  import rfc_pkg::*;

  localparam int          MAX_FRAME         = 2048;
  localparam int          RANDOM_BYTES      = 90;
  localparam int          RANDOM_FRAMES     = 3;
  localparam int          DRAIN_LIMIT       = 20000;
  localparam int          SETTLE_CYCLES     = 8;
  localparam logic [7:0]  ICMP_TYPE_REPLY   = 8'd0;
  localparam logic [7:0]  ICMP_TYPE_REQUEST = 8'd8;
  localparam logic [7:0]  PROTO_TCP         = 8'd6;
  localparam logic [15:0] ARP_OP_REPLY      = 16'h0002;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        frame_valid = 1'b0;
  logic        frame_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        verdict_valid;
  logic        verdict_ready = 1'b0;
  logic [3:0]  frame_class;
  logic [15:0] ether_type;
  logic [31:0] peer_ip;
  logic [47:0] peer_mac;
  logic [15:0] echo_id;
  logic [15:0] echo_seq;
  logic [11:0] echo_payload_len;
  logic        cache_valid;
  logic [31:0] cache_ip;
  logic [47:0] cache_mac;

  int mismatch_count;
  int verdicts_pending;
  int verdicts_checked;

  logic [7:0] frame_buf[$];
  int         frames_sent = 0;
  int         bytes_sent = 0;
  logic       no_gaps = 1'b0;
  logic       stall_free = 1'b0;
  int         ready_hold = 0;

  rx_frame_classifier_arp_cache_unit #(
    .MAX_FRAME(MAX_FRAME)
  ) uut (
    .clk(clk),
    .rst(rst),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .verdict_valid(verdict_valid),
    .verdict_ready(verdict_ready),
    .frame_class(frame_class),
    .ether_type(ether_type),
    .peer_ip(peer_ip),
    .peer_mac(peer_mac),
    .echo_id(echo_id),
    .echo_seq(echo_seq),
    .echo_payload_len(echo_payload_len),
    .cache_valid(cache_valid),
    .cache_ip(cache_ip),
    .cache_mac(cache_mac)
  );

  frame_verdict_checker #(
    .MAX_FRAME(MAX_FRAME)
  ) verdict_check (
    .clk(clk),
    .rst(rst),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .verdict_valid(verdict_valid),
    .verdict_ready(verdict_ready),
    .frame_class(frame_class),
    .ether_type(ether_type),
    .peer_ip(peer_ip),
    .peer_mac(peer_mac),
    .echo_id(echo_id),
    .echo_seq(echo_seq),
    .echo_payload_len(echo_payload_len),
    .cache_valid(cache_valid),
    .cache_ip(cache_ip),
    .cache_mac(cache_mac),
    .mismatch_count(mismatch_count),
    .verdicts_pending(verdicts_pending),
    .verdicts_checked(verdicts_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    int r;
    if (rst) begin
      verdict_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (stall_free || r < 60) begin
        verdict_ready <= 1'b1;
        ready_hold <= $urandom_range(0, 6);
      end else if (r < 92) begin
        verdict_ready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        verdict_ready <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  function automatic void put8(input int idx, input logic [7:0] v);
    if (idx < frame_buf.size()) begin
      frame_buf[idx] = v;
    end
  endfunction

  function automatic void put16(input int idx, input logic [15:0] v);
    put8(idx, v[15:8]);
    put8(idx + 1, v[7:0]);
  endfunction

  function automatic void put32(input int idx, input logic [31:0] v);
    put16(idx, v[31:16]);
    put16(idx + 2, v[15:0]);
  endfunction

  function automatic void new_frame(input int len, input logic [15:0] etype,
                                    input int fill = -1);
    frame_buf.delete();
    for (int i = 0; i < len; i++) begin
      frame_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    end
    put16(OFS_TYPE_HI, etype);
  endfunction

  function automatic void arp_frame(input int len, input logic [15:0] op,
                                    input logic [47:0] mac, input logic [31:0] ip,
                                    input int fill = -1);
    new_frame(len, TYPE_ARP, fill);
    put16(OFS_ARP_OP_HI, op);
    put16(OFS_ARP_MAC_LO, mac[47:32]);
    put32(OFS_ARP_MAC_LO + 2, mac[31:0]);
    put32(OFS_ARP_IP_LO, ip);
  endfunction

  function automatic void ipv4_frame(input int len, input logic [7:0] ver_ihl,
                                     input logic [15:0] tot, input logic [7:0] proto,
                                     input logic [7:0] itype, input logic [7:0] icode);
    int hdr;
    new_frame(len, TYPE_IPV4);
    hdr = ETH_HDR_LEN + int'(ver_ihl & IHL_MASK) * IHL_UNIT;
    put8(hdr, itype);
    put8(hdr + 1, icode);
    put8(OFS_IP_VER_IHL, ver_ihl);
    put16(OFS_IP_TOT_HI, tot);
    put8(OFS_IP_PROTO, proto);
  endfunction

  function automatic void echo_frame(input int ihl, input int payload, input int pad);
    int tot;
    tot = ihl * IHL_UNIT + ICMP_HDR_LEN + payload;
    ipv4_frame(ETH_HDR_LEN + tot + pad, {IPV4_VERSION, 4'(ihl)}, 16'(tot), PROTO_ICMP,
               ICMP_TYPE_REPLY, 8'h00);
  endfunction

  task automatic send_frame();
    int r;
    int gap;
    for (int i = 0; i < frame_buf.size(); i++) begin
      frame_valid <= 1'b1;
      data_byte <= frame_buf[i];
      last_byte <= (i == frame_buf.size() - 1);
      @(posedge clk);
      while (!frame_ready) @(posedge clk);
      bytes_sent++;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 70) begin
        gap = 0;
      end else if (r < 95) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(8, 40);
      end
      if (gap > 0) begin
        frame_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    frames_sent++;
    no_gaps = ($urandom_range(0, 3) == 0);
    stall_free <= ($urandom_range(0, 3) == 0);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    frame_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int r;
    int ihl;
    int hdr;
    int cut;
    int random_frames;
    int random_start;
    logic [7:0] proto;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Runts and other ethertypes, with all-zero and all-one words.
    new_frame(1, 16'h0000);
    send_frame();
    new_frame(13, 16'h0000);
    send_frame();
    new_frame(14, 16'hFFFF, 255);
    send_frame();
    new_frame(20, 16'h0000, 0);
    send_frame();

    // ARP: one byte short, shortest full frame, reply and odd opcode.
    arp_frame(41, ARP_OP_REQUEST, 48'({$urandom, $urandom}), $urandom);
    send_frame();
    arp_frame(42, ARP_OP_REQUEST, {48{1'b1}}, 32'hFFFF_FFFF, 255);
    send_frame();
    arp_frame(42, ARP_OP_REPLY, '0, '0, 0);
    send_frame();
    arp_frame(44, 16'h0100, 48'({$urandom, $urandom}), $urandom);
    send_frame();

    // Echo replies at the smallest and largest header.
    echo_frame(5, 0, 0);
    send_frame();
    echo_frame(15, 4, 1);
    send_frame();

    // Malformed IPv4 headers.
    ipv4_frame(34, 8'h65, 16'd20, PROTO_ICMP, ICMP_TYPE_REPLY, 8'h00);
    send_frame();
    ipv4_frame(34, 8'h44, 16'd20, PROTO_ICMP, ICMP_TYPE_REPLY, 8'h00);
    send_frame();
    ipv4_frame(34, 8'h40, 16'd20, PROTO_ICMP, ICMP_TYPE_REPLY, 8'h00);
    send_frame();
    ipv4_frame(33, 8'h45, 16'd19, PROTO_ICMP, ICMP_TYPE_REPLY, 8'h00);
    send_frame();
    ipv4_frame(54, 8'h4F, 16'd40, PROTO_ICMP, ICMP_TYPE_REPLY, 8'h00);
    send_frame();
    ipv4_frame(38, 8'h46, 16'd10, PROTO_ICMP, ICMP_TYPE_REPLY, 8'h00);
    send_frame();
    ipv4_frame(34, 8'h45, 16'd21, PROTO_ICMP, ICMP_TYPE_REPLY, 8'h00);
    send_frame();

    // Not ICMP, short ICMP, echo request, nonzero code.
    ipv4_frame(34, 8'h45, 16'd20, PROTO_TCP, ICMP_TYPE_REPLY, 8'h00);
    send_frame();
    ipv4_frame(38, 8'h45, 16'd24, PROTO_ICMP, ICMP_TYPE_REPLY, 8'h00);
    send_frame();
    ipv4_frame(42, 8'h45, 16'd28, PROTO_ICMP, ICMP_TYPE_REQUEST, 8'h00);
    send_frame();
    ipv4_frame(42, 8'h45, 16'd28, PROTO_ICMP, ICMP_TYPE_REPLY, 8'h03);
    send_frame();

    // Let every verdict out before the random part starts.
    drain();

    random_frames = 0;
    random_start = bytes_sent;
    while (random_frames < RANDOM_FRAMES || bytes_sent - random_start < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(5, 15);
      if (r < 30) begin
        echo_frame(ihl, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300)
                                                      : $urandom_range(0, 24),
                   $urandom_range(0, 4));
      end else if (r < 50) begin
        arp_frame(($urandom_range(0, 9) == 0) ? $urandom_range(14, 41)
                                              : $urandom_range(42, 64),
                  ($urandom_range(0, 1) == 0) ? ARP_OP_REQUEST
                  : (($urandom_range(0, 1) == 0) ? ARP_OP_REPLY : 16'($urandom)),
                  48'({$urandom, $urandom}), $urandom);
      end else if (r < 65) begin
        echo_frame(ihl, $urandom_range(0, 16), $urandom_range(0, 4));
        hdr = ETH_HDR_LEN + ihl * IHL_UNIT;
        case ($urandom_range(0, 6))
          0: put8(hdr, 8'($urandom_range(1, 255)));
          1: put8(hdr + 1, 8'($urandom_range(1, 255)));
          2: put16(OFS_IP_TOT_HI, 16'(ihl * IHL_UNIT + $urandom_range(0, 7)));
          3: put8(OFS_IP_VER_IHL, {4'($urandom_range(0, 15)), 4'(ihl)});
          4: put16(OFS_IP_TOT_HI, 16'($urandom));
          5: put8(OFS_IP_VER_IHL, 8'($urandom));
          default: begin
            cut = $urandom_range(1, frame_buf.size());
            while (frame_buf.size() > cut) void'(frame_buf.pop_back());
          end
        endcase
      end else if (r < 80) begin
        proto = 8'($urandom);
        if (proto == PROTO_ICMP) begin
          proto = PROTO_TCP;
        end
        cut = $urandom_range(20, 60);
        ipv4_frame(ETH_HDR_LEN + cut + $urandom_range(0, 6), 8'h45, 16'(cut), proto,
                   8'($urandom), 8'($urandom));
      end else if (r < 90) begin
        new_frame($urandom_range(1, 80),
                  ($urandom_range(0, 3) == 0) ? TYPE_IPV4 : 16'($urandom));
      end else if (r < 95) begin
        new_frame($urandom_range(1, 13), 16'($urandom));
      end else begin
        drain();
        echo_frame(ihl, $urandom_range(0, 24), $urandom_range(0, 4));
      end
      send_frame();
      random_frames++;
    end

    drain();
    $display("Sent %0d frames (%0d words): runts, other types, ARP, IPv4/ICMP, malformed",
             frames_sent, bytes_sent);
    $display("and truncated frames; %0d verdicts compared, %0d mismatches, %0d outstanding.",
             verdicts_checked, mismatch_count, verdicts_pending);
    if (mismatch_count == 0 && verdicts_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: the run did not complete in the allotted time.");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
